>>> src/tif_pkg.sv
// shared types and constants for the tensor index fill block
package tif_pkg;

	// width of the coordinate carried between front and back (covers the largest dimension)
	localparam int COORD_W = 16;
	// widest element the item record can carry
	localparam int ELEM_MAX_W = 64;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// operation codes on the input tuser field
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_MARK  = 2'd1,
		OP_ELEM  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DIM_SIZE    = 2'd0,
		REG_INNER_COUNT = 2'd1,
		REG_FILL_VALUE  = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	// one classified item handed from front to back
	typedef struct packed {
		op_t                   kind;
		logic                  status;
		logic                  last;
		logic [COORD_W-1:0]    coord;
		logic [ELEM_MAX_W-1:0] elem;
	} tif_item_t;

endpackage

>>> src/tif_front.sv
// front part: classifies beats, wraps mark indexes and tracks element coordinates
module tif_front import tif_pkg::*; #(
	parameter int MAX_DIM_SIZE = 1024,
	parameter int ELEMENT_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [1:0]               operation,
	input  logic [10:0]              index_value,
	input  logic [ELEMENT_WIDTH-1:0] element_bits,
	input  logic                     last_element,
	input  logic [10:0]              dim_size,
	input  logic [31:0]              inner_count,
	output tif_item_t                item
);

	localparam int CW = (MAX_DIM_SIZE > 1) ? $clog2(MAX_DIM_SIZE) : 1;
	// wide enough for the largest size plus sign
	localparam int SW = 18;

	logic [CW-1:0]        coord_q;
	logic [31:0]          inner_pos_q;
	op_t                  op;
	logic [SW-1:0]        size_eff;
	logic signed [SW-1:0] size_s;
	logic signed [SW-1:0] idx_s;
	logic signed [SW-1:0] idx_wrap;
	logic                 idx_bad;
	logic [31:0]          inner_eff;
	logic [32:0]          pos_inc;
	logic                 pos_wrap;
	logic [SW-1:0]        coord_inc;
	logic                 coord_wrap;

	assign op = op_t'(operation);

	// dimension size saturated to one and to the maximum
	always_comb begin
		if (dim_size == 11'd0) begin
			size_eff = SW'(1);
		end else if (SW'(dim_size) > SW'(MAX_DIM_SIZE)) begin
			size_eff = SW'(MAX_DIM_SIZE);
		end else begin
			size_eff = SW'(dim_size);
		end
	end

	// mark index range check and wrap of negative indexes
	always_comb begin
		size_s   = signed'(size_eff);
		idx_s    = signed'({{(SW-11){index_value[10]}}, index_value});
		idx_bad  = (idx_s < -size_s) || (idx_s >= size_s);
		idx_wrap = (idx_s < 0) ? (idx_s + size_s) : idx_s;
	end

	// next values of the inner and coordinate counters
	always_comb begin
		inner_eff  = (inner_count == 32'd0) ? 32'd1 : inner_count;
		pos_inc    = {1'b0, inner_pos_q} + 33'd1;
		pos_wrap   = pos_inc >= {1'b0, inner_eff};
		coord_inc  = SW'(coord_q) + SW'(1);
		coord_wrap = coord_inc >= size_eff;
	end

	// classified item
	always_comb begin
		item.kind   = op;
		item.status = 1'b0;
		item.last   = 1'b0;
		item.coord  = COORD_W'(coord_q);
		item.elem   = '0;
		case (op)
			OP_MARK: begin
				if (idx_bad) begin
					item.kind   = OP_NONE;
					item.status = 1'b1;
				end
				item.coord = COORD_W'(idx_wrap);
			end
			OP_ELEM: begin
				item.last = last_element;
				item.elem = ELEM_MAX_W'(element_bits);
			end
			default: begin
				item.coord = COORD_W'(coord_q);
			end
		endcase
	end

	// position counters advance on accepted element beats; a clear or a last element resets them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q     <= '0;
			inner_pos_q <= '0;
		end else if (accept) begin
			case (op)
				OP_CLEAR: begin
					coord_q     <= '0;
					inner_pos_q <= '0;
				end
				OP_ELEM: begin
					if (last_element) begin
						coord_q     <= '0;
						inner_pos_q <= '0;
					end else if (pos_wrap) begin
						inner_pos_q <= '0;
						coord_q     <= coord_wrap ? '0 : CW'(coord_inc);
					end else begin
						inner_pos_q <= pos_inc[31:0];
					end
				end
				default: begin
					coord_q <= coord_q;
				end
			endcase
		end
	end

endmodule

>>> src/tif_queue.sv
// short queue of classified items between front and back
module tif_queue import tif_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tif_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output tif_item_t head
);

	tif_item_t         slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/tif_back.sv
// back part: mark bitmap in row memory, element lookup and output register
module tif_back import tif_pkg::*; #(
	parameter int MAX_DIM_SIZE = 1024,
	parameter int ELEMENT_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  tif_item_t                head,
	output logic                     pop,
	input  logic [ELEMENT_WIDTH-1:0] fill_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ELEMENT_WIDTH-1:0] element_out,
	output logic                     status,
	output logic                     last_out
);

	// bitmap rows: narrow rows for small sizes, wide rows keep the row count at 256 or less
	localparam int ROW_W  = (MAX_DIM_SIZE > 8192) ? 256 : 32;
	localparam int ROW_SH = $clog2(ROW_W);
	localparam int ROWS   = (MAX_DIM_SIZE + ROW_W - 1) / ROW_W;
	localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [ROW_W-1:0]         mem [ROWS];
	logic [ROWS-1:0]          row_vld_q;
	logic [ROW_W-1:0]         rd_q;
	logic                     fwd_hit_q;
	logic [ROW_W-1:0]         fwd_q;

	tif_item_t                item_s2;
	logic                     valid_s2;
	logic                     fire_s2;
	logic [RIDX_W-1:0]        head_row;
	logic [RIDX_W-1:0]        row_s2;
	logic [ROW_SH-1:0]        bit_s2;
	logic [ROW_W-1:0]         row_eff;
	logic [ROW_W-1:0]         row_new;
	logic                     wr_en;
	logic                     hit;

	logic                     out_valid_q;
	logic [ELEMENT_WIDTH-1:0] out_elem_q;
	logic                     out_status_q;
	logic                     out_last_q;

	assign head_row = head.coord[ROW_SH +: RIDX_W];
	assign row_s2   = item_s2.coord[ROW_SH +: RIDX_W];
	assign bit_s2   = item_s2.coord[ROW_SH-1:0];

	// stage handshake: s2 drains into the output register
	assign fire_s2 = valid_s2 && (!out_valid_q || out_ready);
	assign pop     = head_valid && (!valid_s2 || fire_s2);

	// current row: forwarded write, memory data, or empty when the row is stale
	always_comb begin
		if (fwd_hit_q) begin
			row_eff = fwd_q;
		end else if (row_vld_q[row_s2]) begin
			row_eff = rd_q;
		end else begin
			row_eff = '0;
		end
		row_new         = row_eff;
		row_new[bit_s2] = 1'b1;
		hit             = row_eff[bit_s2];
		wr_en           = fire_s2 && (item_s2.kind == OP_MARK);
	end

	// row memory: read when an item enters s2, written when a mark leaves it
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q      <= mem[head_row];
			fwd_hit_q <= wr_en && (row_s2 == head_row);
			fwd_q     <= row_new;
		end
		if (wr_en) begin
			mem[row_s2] <= row_new;
		end
	end

	// row valid bits: a clear empties every row at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (fire_s2 && (item_s2.kind == OP_CLEAR)) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[row_s2] <= 1'b1;
		end
	end

	// s2 item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (fire_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			out_status_q <= item_s2.status;
			out_last_q   <= item_s2.last;
			if (item_s2.kind == OP_ELEM) begin
				out_elem_q <= hit ? fill_value : item_s2.elem[ELEMENT_WIDTH-1:0];
			end else begin
				out_elem_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign element_out = out_elem_q;
	assign status      = out_status_q;
	assign last_out    = out_last_q;

endmodule

>>> src/tensor_index_fill.sv
// top level of the tensor index fill block: configuration registers and part wiring
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  tuser operation, tdata index + element, tlast last element
// m_*      out  m_tvalid / m_tready  tdata filled element, tuser status, tlast last element
// cfg_*    in   cfg_en               cfg_addr register index, cfg_data value
//
// one beat per cycle sustained in both directions while m_* does not stall; a beat accepted on
// s_* is written into the queue at that edge, then passes the bitmap read stage and then the
// output register before it shows on m_*
// the mark bitmap reads one memory row per beat; the row written by the beat just ahead is
// forwarded, so marks and elements may follow each other in any order at full rate
// reset clears every mark at once through per-row valid bits; no clearing sweep is needed
// a stall on m_* fills the four-beat queue before s_tready drops
module tensor_index_fill import tif_pkg::*; #(
	parameter int MAX_DIM_SIZE = 1024,
	parameter int ELEMENT_WIDTH = 64,
	localparam int S_TDATA_W = ((11 + ELEMENT_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_W = ((ELEMENT_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input beats
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // index_value, element_bits
	input  logic [1:0]           s_tuser,  // operation
	input  logic                 s_tlast,
	// result beats
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // element_out
	output logic                 m_tuser,  // status
	output logic                 m_tlast,
	// configuration writes
	input  logic                 cfg_en,
	input  logic [1:0]           cfg_addr,
	input  logic [63:0]          cfg_data
);

	logic [10:0]              dim_size_q;
	logic [31:0]              inner_count_q;
	logic [63:0]              fill_value_q;

	logic                     accept;
	logic                     q_full;
	tif_item_t                front_item;
	logic                     head_valid;
	tif_item_t                head;
	logic                     pop;
	logic [ELEMENT_WIDTH-1:0] element_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_size_q    <= 11'd1;
			inner_count_q <= 32'd1;
			fill_value_q  <= 64'd0;
		end else if (cfg_en) begin
			case (reg_idx_t'(cfg_addr))
				REG_DIM_SIZE:    dim_size_q    <= cfg_data[10:0];
				REG_INNER_COUNT: inner_count_q <= cfg_data[31:0];
				REG_FILL_VALUE:  fill_value_q  <= cfg_data;
				default:         dim_size_q    <= dim_size_q;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	tif_front #(
		.MAX_DIM_SIZE  (MAX_DIM_SIZE),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (s_tuser),
		.index_value  (s_tdata[10:0]),
		.element_bits (s_tdata[11 +: ELEMENT_WIDTH]),
		.last_element (s_tlast),
		.dim_size     (dim_size_q),
		.inner_count  (inner_count_q),
		.item         (front_item)
	);

	tif_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tif_back #(
		.MAX_DIM_SIZE  (MAX_DIM_SIZE),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.fill_value  (fill_value_q[ELEMENT_WIDTH-1:0]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.element_out (element_out),
		.status      (m_tuser),
		.last_out    (m_tlast)
	);

	assign m_tdata = M_TDATA_W'(element_out);

endmodule

>>> sim/tif_fill_checker.sv
// checker for the tensor index fill block: watches all channels, predicts each result, compares
module tif_fill_checker import tif_pkg::*; #(
	parameter int MAX_DIM_SIZE = 1024,
	parameter int ELEMENT_WIDTH = 64,
	parameter int S_TDATA_W = 80,
	parameter int M_TDATA_W = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // index_value, element_bits
	input  logic [1:0]           s_tuser,  // operation
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // element_out
	input  logic                 m_tuser,  // status
	input  logic                 m_tlast,
	input  logic                 cfg_en,
	input  logic [1:0]           cfg_addr,
	input  logic [63:0]          cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [ELEMENT_WIDTH-1:0] elem;
		logic                     status;
		logic                     last;
	} fill_beat_t;

	// results still owed by the block, newest first, oldest at the back
	fill_beat_t expected_beats[$];

	// own copy of the registers and the block state
	logic [10:0] dim_reg;
	logic [31:0] inner_reg;
	logic [63:0] fill_reg;
	bit          marks [MAX_DIM_SIZE];
	logic [31:0] inner_pos;
	logic [31:0] coord;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// one input beat: update marks and counters, return the result it causes
	function automatic fill_beat_t fill_prediction(op_t op, logic [10:0] raw,
			logic [ELEMENT_WIDTH-1:0] elem, logic last);
		fill_beat_t r;
		int size;
		int idx;
		longint inner;
		bit hit;
		r = '0;
		if (dim_reg == 11'd0)
			size = 1;
		else if (int'(dim_reg) > MAX_DIM_SIZE)
			size = MAX_DIM_SIZE;
		else
			size = int'(dim_reg);
		case (op)
			OP_CLEAR: begin
				marks = '{default: 1'b0};
				inner_pos = '0;
				coord = '0;
			end
			OP_MARK: begin
				idx = int'($signed(raw));
				if (idx < -size || idx >= size) begin
					r.status = 1'b1;
				end else begin
					if (idx < 0)
						idx += size;
					if (idx < MAX_DIM_SIZE)
						marks[idx] = 1'b1;
				end
			end
			OP_ELEM: begin
				inner = (inner_reg == 32'd0) ? 64'd1 : longint'(inner_reg);
				hit = (coord < MAX_DIM_SIZE) && marks[coord];
				r.elem = hit ? fill_reg[ELEMENT_WIDTH-1:0] : elem;
				r.last = last;
				if (last) begin
					inner_pos = '0;
					coord = '0;
				end else if (longint'(inner_pos) + 1 >= inner) begin
					inner_pos = '0;
					if (longint'(coord) + 1 >= size)
						coord = '0;
					else
						coord = coord + 32'd1;
				end else begin
					inner_pos = inner_pos + 32'd1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// sample at the falling edge, where every signal has settled for the next rising edge
	always @(negedge clk) begin
		fill_beat_t exp_beat;
		if (!arst_n) begin
			dim_reg = 11'd1;
			inner_reg = 32'd1;
			fill_reg = '0;
			marks = '{default: 1'b0};
			inner_pos = '0;
			coord = '0;
			expected_beats.delete();
		end else begin
			// register writes
			if (cfg_en === 1'b1) begin
				case (cfg_addr)
					REG_DIM_SIZE:    dim_reg = cfg_data[10:0];
					REG_INNER_COUNT: inner_reg = cfg_data[31:0];
					REG_FILL_VALUE:  fill_reg = cfg_data;
					default: ;
				endcase
			end
			// input beat
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				expected_beats.push_front(fill_prediction(op_t'(s_tuser), s_tdata[10:0],
					s_tdata[11 +: ELEMENT_WIDTH], s_tlast));
			// result beat against the oldest expectation
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (expected_beats.size() == 0) begin
					$display("%0t unexpected result beat: element %h status %b last %b",
						$time, m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					exp_beat = expected_beats.pop_back();
					if (m_tdata[ELEMENT_WIDTH-1:0] !== exp_beat.elem) begin
						$display("%0t element mismatch: expected %h actual %h",
							$time, exp_beat.elem, m_tdata[ELEMENT_WIDTH-1:0]);
						fail_count++;
					end
					if (m_tuser !== exp_beat.status) begin
						$display("%0t status mismatch: expected %b actual %b",
							$time, exp_beat.status, m_tuser);
						fail_count++;
					end
					if (m_tlast !== exp_beat.last) begin
						$display("%0t last mismatch: expected %b actual %b",
							$time, exp_beat.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
		pending = expected_beats.size();
	end

endmodule

>>> sim/tb_tensor_index_fill.sv
// testbench top for the tensor index fill block: clock, reset, stimulus and verdict
module tb_tensor_index_fill;
	import tif_pkg::*;

	localparam int MAX_DIM = 1024;
	localparam int ELEM_W = 64;
	localparam int S_W = ((11 + ELEM_W + 7) / 8) * 8;
	localparam int M_W = ((ELEM_W + 7) / 8) * 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT_BEAT = 60;
	localparam int HOLD_CYCLES = 200;
	localparam int ELEM_CAP = 48;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;   // index_value, element_bits
	logic [1:0]     s_tuser;   // operation
	logic           s_tlast;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;   // element_out
	logic           m_tuser;   // status
	logic           m_tlast;
	logic           cfg_en;
	logic [1:0]     cfg_addr;
	logic [63:0]    cfg_data;

	int     fails;
	int     pending;
	int     sent_count = 0;
	int     idle_cycles = 0;
	bit     tx_gaps_on = 1'b1;
	bit     rx_gaps_on = 1'b1;
	int     cur_size = 1;
	longint cur_inner = 1;

	tensor_index_fill #(.MAX_DIM_SIZE(MAX_DIM), .ELEMENT_WIDTH(ELEM_W)) dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_en, .cfg_addr, .cfg_data
	);

	tif_fill_checker #(.MAX_DIM_SIZE(MAX_DIM), .ELEMENT_WIDTH(ELEM_W),
		.S_TDATA_W(S_W), .M_TDATA_W(M_W)) checker_i (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.cfg_en, .cfg_addr, .cfg_data,
		.fail_count(fails), .pending(pending)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly legal indices for the current size, some raw 11-bit noise
	function automatic int pick_index();
		if ($urandom_range(0, 4) != 0)
			return int'($urandom_range(0, 2 * cur_size - 1)) - cur_size;
		return int'($urandom_range(0, 2047));
	endfunction

	// offer one input beat after a random gap, return at the edge that takes it
	task automatic send_beat(op_t op, int index, logic [63:0] elem, logic last);
		int gap;
		logic [S_W-1:0] word;
		gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[10:0] = index[10:0];
		word[11 +: ELEM_W] = elem[ELEM_W-1:0];
		s_tdata <= word;
		s_tuser <= op;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(negedge clk);
		while (s_tready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	// stop offering and wait until every result is out and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t addr, logic [63:0] value);
		cfg_en <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// idle the block, then write all registers
	task automatic set_config(int dim, logic [31:0] inner, logic [63:0] fill, bit touch_unused);
		drain();
		write_reg(REG_DIM_SIZE, 64'(dim));
		write_reg(REG_INNER_COUNT, 64'(inner));
		write_reg(REG_FILL_VALUE, fill);
		if (touch_unused)
			write_reg(REG_UNUSED, rand64());
		cfg_en <= 1'b0;
		if (dim[10:0] == 11'd0)
			cur_size = 1;
		else if (int'(dim[10:0]) > MAX_DIM)
			cur_size = MAX_DIM;
		else
			cur_size = int'(dim[10:0]);
		cur_inner = (inner == 32'd0) ? 1 : longint'(inner);
	endtask

	// mostly whole tensors (clear, marks, elements), the rest single noise beats
	task automatic run_phase(int n_items);
		int stop_at;
		int n_marks;
		int n_elems;
		int k;
		bit complete;
		bit early;
		longint full;
		stop_at = sent_count + n_items;
		tx_gaps_on = ($urandom_range(0, 3) != 0);
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 9) != 0)
					send_beat(OP_CLEAR, int'($urandom), rand64(), 1'($urandom));
				n_marks = $urandom_range(0, (cur_size < 6) ? cur_size : 6);
				repeat (n_marks)
					send_beat(OP_MARK, pick_index(), rand64(), 1'($urandom));
				full = longint'(cur_size) * cur_inner;
				n_elems = (full > ELEM_CAP) ? $urandom_range(8, ELEM_CAP) : int'(full);
				complete = ($urandom_range(0, 6) != 0);
				if (!complete)
					n_elems = $urandom_range(1, n_elems);
				for (k = 0; k < n_elems; k++) begin
					early = ($urandom_range(0, 29) == 0);
					send_beat(OP_ELEM, int'($urandom), rand64(),
						early || (complete && k == n_elems - 1));
				end
			end else begin
				send_beat(op_t'($urandom_range(0, 3)), int'($urandom), rand64(), 1'($urandom));
			end
		end
	endtask

	// result side: random hold-offs, one long stall to back the block up
	initial begin : result_sink
		int gap;
		int beats;
		beats = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (beats == HOLD_AT_BEAT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = rx_gaps_on ? $urandom_range(0, 8) : 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (m_tvalid !== 1'b1)
				@(negedge clk);
			@(posedge clk);
			beats++;
			if (beats % 64 == 0)
				rx_gaps_on = ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int dim;
		logic [31:0] inner;
		int roll;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_CLEAR;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_en = 1'b0;
		cfg_addr = REG_DIM_SIZE;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scalar tensor at reset settings: indices -1 and 0 legal, the rest rejected
		send_beat(OP_ELEM, 0, '1, 1'b0);
		send_beat(OP_MARK, 0, rand64(), 1'b0);
		send_beat(OP_ELEM, 0, rand64(), 1'b0);
		send_beat(OP_MARK, -1, rand64(), 1'b1);
		send_beat(OP_MARK, 1, rand64(), 1'b0);
		send_beat(OP_MARK, -2, rand64(), 1'b0);
		send_beat(OP_MARK, 1023, '1, 1'b0);
		send_beat(OP_MARK, -1024, '0, 1'b1);
		send_beat(OP_NONE, int'($urandom), rand64(), 1'b1);
		send_beat(OP_ELEM, 0, '0, 1'b1);
		send_beat(OP_CLEAR, 0, rand64(), 1'b0);
		send_beat(OP_ELEM, 0, rand64(), 1'b0);

		// small tensor: bounds of the index range and one full pass
		set_config(4, 32'd2, '1, 1'b1);
		send_beat(OP_CLEAR, 0, '0, 1'b0);
		send_beat(OP_MARK, -4, rand64(), 1'b0);
		send_beat(OP_MARK, 3, rand64(), 1'b0);
		send_beat(OP_MARK, 4, rand64(), 1'b0);
		send_beat(OP_MARK, -5, rand64(), 1'b0);
		for (int k = 0; k < 8; k++)
			send_beat(OP_ELEM, 0, rand64(), k == 7);

		// extreme settings
		set_config(MAX_DIM, 32'd1, rand64(), 1'b0);
		run_phase(80);
		set_config(2047, 32'd3, rand64(), 1'b0);
		run_phase(80);
		set_config(0, 32'd0, '0, 1'b0);
		run_phase(80);
		set_config(5, 32'hFFFF_FFFF, '1, 1'b0);
		run_phase(80);
		set_config(1, 32'd1, rand64(), 1'b0);
		run_phase(80);

		// random settings, mostly small sizes
		repeat (7) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				dim = $urandom_range(1, 8);
			else if (roll < 90)
				dim = $urandom_range(9, 64);
			else
				dim = $urandom_range(65, 2047);
			roll = $urandom_range(0, 99);
			if (roll < 70)
				inner = $urandom_range(1, 4);
			else if (roll < 90)
				inner = $urandom_range(5, 16);
			else
				inner = $urandom;
			set_config(dim, inner, rand64(), 1'b0);
			run_phase(85);
		end

		drain();
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
src/tif_pkg.sv
src/tif_front.sv
src/tif_queue.sv
src/tif_back.sv
src/tensor_index_fill.sv
sim/tif_fill_checker.sv
sim/tb_tensor_index_fill.sv
